// ===== design/i2p_pkg.sv =====
// Shared constants, types and character helpers for the infix-to-postfix converter.
`default_nettype none
package i2p_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int BUF_DEPTH   = STACK_DEPTH + 1;
   localparam int BUF_AW      = $clog2(BUF_DEPTH);
   localparam int NUM_W       = $clog2(BUF_DEPTH + 1);
   localparam int CHAR_W      = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   localparam logic [1:0] STAT_OK              = 2'd0;
   localparam logic [1:0] STAT_UNMATCHED_CLOSE = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW        = 2'd2;
   localparam logic [1:0] STAT_UNMATCHED_OPEN  = 2'd3;

   typedef enum logic [2:0] {
      CLS_OPERAND,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OPERATOR,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic       ready;
      logic       push;
      logic       pop;
      logic       emit_char;
      logic       emit_top;
      logic       set_err;
      logic [1:0] err_code;
      logic       out_data;
      logic       out_empty;
   } i2p_cmd_type;

   typedef struct packed {
      logic           accepted;
      char_class_type cls;
      logic           last;
      logic           cnt_zero;
      logic           stack_full;
      logic           top_open;
      logic           top_pops;
      logic           n_zero;
      logic           k_final;
      logic           out_free;
   } i2p_stat_type;

   // Precedence; zero means not an operator, so a stacked '(' never pops.
   function automatic logic [1:0] op_rank(input logic [CHAR_W-1:0] ch);
      logic [1:0] r;
      r = 2'd0;
      if (ch == CH_CARET) r = 2'd3;
      else if (ch == CH_STAR || ch == CH_SLASH) r = 2'd2;
      else if (ch == CH_PLUS || ch == CH_MINUS) r = 2'd1;
      return r;
   endfunction

   function automatic char_class_type classify(input logic [CHAR_W-1:0] ch);
      char_class_type k;
      if ((ch >= CH_LO_A && ch <= CH_LO_Z) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
          (ch >= CH_ZERO && ch <= CH_NINE)) k = CLS_OPERAND;
      else if (ch == CH_OPEN) k = CLS_OPEN;
      else if (ch == CH_CLOSE) k = CLS_CLOSE;
      else if (op_rank(ch) != 2'd0) k = CLS_OPERATOR;
      else k = CLS_OTHER;
      return k;
   endfunction

endpackage
`default_nettype wire

// ===== design/i2p_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/i2p_ctrl.sv =====
// Sequencer that steps one character through push, pop, flush and replay.
`default_nettype none
module i2p_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2p_pkg::i2p_stat_type stat,
   output i2p_pkg::i2p_cmd_type      cmd
);
   import i2p_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_CLOSE_RD,
      S_CLOSE_EV,
      S_OP_RD,
      S_OP_EV,
      S_OP_PUSH,
      S_POST,
      S_FLUSH_RD,
      S_FLUSH_EV,
      S_REP_RD,
      S_REP_OUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.accepted) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.cls)
               CLS_OPERAND: begin
                  cmd.emit_char = 1'b1;
                  state_in      = S_POST;
               end
               CLS_OPEN: begin
                  if (stat.stack_full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = STAT_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
                  state_in = S_POST;
               end
               CLS_CLOSE:    state_in = S_CLOSE_RD;
               CLS_OPERATOR: state_in = S_OP_RD;
               default:      state_in = S_POST;
            endcase
         end
         // The stack read address follows the count, so each RD state
         // waits out the RAM latency before the top is examined.
         S_CLOSE_RD: begin
            if (stat.cnt_zero) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STAT_UNMATCHED_CLOSE;
               state_in     = S_POST;
            end else begin
               state_in = S_CLOSE_EV;
            end
         end
         S_CLOSE_EV: begin
            cmd.pop = 1'b1;
            if (stat.top_open) begin
               state_in = S_POST;
            end else begin
               cmd.emit_top = 1'b1;
               state_in     = S_CLOSE_RD;
            end
         end
         S_OP_RD: begin
            state_in = stat.cnt_zero ? S_OP_PUSH : S_OP_EV;
         end
         S_OP_EV: begin
            if (stat.top_pops) begin
               cmd.pop      = 1'b1;
               cmd.emit_top = 1'b1;
               state_in     = S_OP_RD;
            end else begin
               state_in = S_OP_PUSH;
            end
         end
         S_OP_PUSH: begin
            if (stat.stack_full) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STAT_OVERFLOW;
            end else begin
               cmd.push = 1'b1;
            end
            state_in = S_POST;
         end
         S_POST: begin
            state_in = stat.last ? S_FLUSH_RD : S_REP_RD;
         end
         S_FLUSH_RD: begin
            state_in = stat.cnt_zero ? S_REP_RD : S_FLUSH_EV;
         end
         S_FLUSH_EV: begin
            cmd.pop = 1'b1;
            if (stat.top_open) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STAT_UNMATCHED_OPEN;
            end else begin
               cmd.emit_top = 1'b1;
            end
            state_in = S_FLUSH_RD;
         end
         S_REP_RD: begin
            state_in = S_REP_OUT;
         end
         S_REP_OUT: begin
            if (stat.out_free) begin
               if (stat.n_zero) begin
                  cmd.out_empty = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.out_data = 1'b1;
                  state_in     = stat.k_final ? S_IDLE : S_REP_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTH
   a_one_out_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_data && cmd.out_empty))
      else $error("both output load commands issued together");
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop issued in the same cycle");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      stat.accepted |=> state_ff == S_DISPATCH)
      else $error("accepted transaction not dispatched");
`endif

endmodule
`default_nettype wire

// ===== design/i2p_datapath.sv =====
// Operator stack, emit buffer, counters and the output register.
`default_nettype none
module i2p_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire i2p_pkg::i2p_cmd_type              cmd,
   output i2p_pkg::i2p_stat_type                  stat,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [i2p_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [i2p_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);
   import i2p_pkg::*;

   logic                accept;
   logic [CHAR_W-1:0]   char_ff;
   logic                last_ff;
   logic [1:0]          status_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [NUM_W-1:0]    n_ff;
   logic [BUF_AW-1:0]   k_ff;
   logic [CNT_W-1:0]    cnt_m1;
   logic [CHAR_W-1:0]   top_char;
   logic [CHAR_W-1:0]   buf_rd;
   logic                buf_we;
   logic [CHAR_W-1:0]   buf_wd;
   logic                out_free;
   logic                out_load;

   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic                rsp_char_valid_ff;
   logic                rsp_run_last_ff;
   logic                rsp_expr_end_ff;
   logic [1:0]          rsp_status_ff;

   assign req_tready = cmd.ready;
   assign accept     = req_tvalid && cmd.ready;
   assign cnt_m1     = cnt_ff - CNT_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = cmd.out_data || cmd.out_empty;
   assign buf_we     = cmd.emit_char || cmd.emit_top;
   assign buf_wd     = cmd.emit_top ? top_char : char_ff;

   i2p_ram #(.WIDTH(CHAR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (cnt_ff[STK_AW-1:0]),
      .wr_data (char_ff),
      .rd_addr (cnt_m1[STK_AW-1:0]),
      .rd_data (top_char)
   );

   // Emitted characters wait here until the status of the transaction is known.
   i2p_ram #(.WIDTH(CHAR_W), .DEPTH(BUF_DEPTH)) u_emit_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (n_ff[BUF_AW-1:0]),
      .wr_data (buf_wd),
      .rd_addr (k_ff),
      .rd_data (buf_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            n_ff      <= '0;
            k_ff      <= '0;
            status_ff <= STAT_OK;
         end
         if (cmd.push) cnt_ff <= cnt_ff + CNT_W'(1);
         else if (cmd.pop) cnt_ff <= cnt_m1;
         if (buf_we) n_ff <= n_ff + NUM_W'(1);
         if (cmd.set_err && status_ff == STAT_OK) status_ff <= cmd.err_code;
         if (cmd.out_data) k_ff <= k_ff + BUF_AW'(1);
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_tdata[CHAR_W-1:0];
         last_ff <= req_tlast;
      end
      if (out_load) begin
         rsp_char_ff       <= cmd.out_data ? buf_rd : '0;
         rsp_char_valid_ff <= cmd.out_data;
         rsp_run_last_ff   <= cmd.out_empty || stat.k_final;
         rsp_expr_end_ff   <= (cmd.out_empty || stat.k_final) && last_ff;
         rsp_status_ff     <= status_ff;
      end
   end

   always_comb begin
      stat            = '0;
      stat.accepted   = accept;
      stat.cls        = classify(char_ff);
      stat.last       = last_ff;
      stat.cnt_zero   = cnt_ff == '0;
      stat.stack_full = cnt_ff == CNT_W'(STACK_DEPTH);
      stat.top_open   = top_char == CH_OPEN;
      stat.top_pops   = op_rank(char_ff) <= op_rank(top_char);
      stat.n_zero     = n_ff == '0;
      stat.k_final    = NUM_W'(k_ff) == n_ff - NUM_W'(1);
      stat.out_free   = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_status_ff, rsp_run_last_ff, rsp_char_ff});
   assign rsp_tuser  = rsp_char_valid_ff;
   assign rsp_tlast  = rsp_expr_end_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> cnt_ff < CNT_W'(STACK_DEPTH))
      else $error("push on a full stack");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> cnt_ff != '0)
      else $error("pop on an empty stack");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten before it was taken");
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_we |-> n_ff < NUM_W'(BUF_DEPTH))
      else $error("emit buffer overflow");
`endif

endmodule
`default_nettype wire

// ===== design/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
//
//   Channel  Direction  Payload
//   req_*    in         tdata[7:0] in_char; tlast in_last
//   rsp_*    out        tdata[7:0] out_char, [8] run_last, [10:9] status;
//                       tuser char_valid; tlast expr_end
//
// One transaction is handled at a time: it is accepted, dispatched and settled (S_IDLE,
// S_DISPATCH, S_POST), with an S_OP_PUSH step for an operator push and an RD step for each
// stack walk that ends on an empty stack, an RD and an EV state per stack entry examined or
// popped (the stack RAM read is registered), and S_REP_RD and S_REP_OUT per result read back from the emit buffer.
// Reset is synchronous and clears the stack count, the sequencer and rsp_tvalid.
// A stalled rsp_tready holds the output register, and holds the sequencer in S_REP_OUT.
`default_nettype none
module infix_to_postfix_converter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [i2p_pkg::REQ_DATA_W-1:0] req_tdata,   // in_char
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [i2p_pkg::RSP_DATA_W-1:0] rsp_tdata,   // out_char, run_last, status
   output logic                                rsp_tuser,   // char_valid
   output logic                                rsp_tlast
);
   import i2p_pkg::*;

   i2p_cmd_type  cmd;
   i2p_stat_type stat;

   i2p_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   i2p_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
